@@ sv/lru_page_replacement_macros.svh @@
// ----------------------------------------------------------------------------
// lru_page_replacement_macros
// assertion macros shared by the page replacement block
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define LRUPR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LRUPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupr_pkg
// sizes, types and helpers of the lru page replacement block
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int MAX_FRAMES  = 16;
   localparam int PAGE_BITS   = 16;
   localparam int IDX_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int RANK_W      = IDX_W;
   localparam int NCNT_W      = $clog2(MAX_FRAMES + 1);
   localparam int CSR_W       = 5;
   localparam int PAGE_IN_W   = 16;
   localparam int FRAME_OUT_W = 4;
   localparam int TOTAL_W     = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_W-1:0]   CSR_RESET = CSR_W'(16);
   localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(MAX_FRAMES - 1);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [0:0] {
      BK_LOOK,
      BK_UPDATE
   } bk_state_type;

   // head of the reference queue
   typedef struct packed {
      logic                 vld;
      logic [PAGE_BITS-1:0] page;
   } fq_head_type;

   function automatic logic [PAGE_BITS-1:0] page_in(input logic [PAGE_IN_W-1:0] x);
      logic [63:0] w;
      w = 64'(x);
      return w[PAGE_BITS-1:0];
   endfunction

   function automatic logic [PAGE_IN_W-1:0] page_out(input logic [PAGE_BITS-1:0] x);
      logic [63:0] w;
      w = 64'(x);
      return w[PAGE_IN_W-1:0];
   endfunction

   function automatic logic [FRAME_OUT_W-1:0] frame_out(input logic [IDX_W-1:0] x);
      logic [63:0] w;
      w = 64'(x);
      return w[FRAME_OUT_W-1:0];
   endfunction

   // zero acts as one, anything above the frame count as the frame count
   function automatic logic [NCNT_W-1:0] active_count(input logic [CSR_W-1:0] x);
      int v;
      v = int'(x);
      if (v < 1) v = 1;
      if (v > MAX_FRAMES) v = MAX_FRAMES;
      return NCNT_W'(v);
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] c);
      return (c == TOTAL_MAX) ? c : c + TOTAL_W'(1);
   endfunction

endpackage

@@ sv/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative lru page replacement with hit and fault totals
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   request   start / busy          req_page_number
//   response  rsp_valid (strobe)    rsp_hit .. rsp_fault_total
//   config    csr_wr_en             csr_wr_data (frames in use)
//
// in the back end each reference passes the look state, for the parallel tag
// compare and victim search, then the update state, for the recency update and tag write.
// a two-entry queue in front accepts references while the back end works;
// busy is high while that queue is full.
// reset clears the queue, every valid bit, every rank and both totals.
// the response strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lru_page_replacement (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lrupr_pkg::PAGE_IN_W-1:0]     req_page_number,
   input  logic                                csr_wr_en,
   input  logic [lrupr_pkg::CSR_W-1:0]         csr_wr_data,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [lrupr_pkg::FRAME_OUT_W-1:0]   rsp_frame_used,
   output logic                                rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_IN_W-1:0]     rsp_evicted_page,
   output logic [lrupr_pkg::TOTAL_W-1:0]       rsp_hit_total,
   output logic [lrupr_pkg::TOTAL_W-1:0]       rsp_fault_total
);

   lrupr_pkg::fq_head_type head;
   logic                   pop;

   lrupr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_page_number (req_page_number),
      .head            (head),
      .pop             (pop)
   );

   lrupr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_used    (rsp_frame_used),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total)
   );

   // back end never finishes two transactions in a row
   `LRUPR_ASSERT_NEXT(a_rsp_spaced, clock, reset,
      rsp_valid, !rsp_valid, "back-to-back responses")
   `LRUPR_ASSERT_IMPLY(a_hit_no_evict, clock, reset,
      rsp_valid && rsp_hit, !rsp_evicted_valid, "eviction on hit")
   `LRUPR_ASSERT_IMPLY(a_evict_page_zero, clock, reset,
      rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0, "evicted page not zero")
   `LRUPR_ASSERT_IMPLY(a_fault_counted, clock, reset,
      rsp_valid && !rsp_hit, rsp_fault_total != '0, "fault not counted")

endmodule

@@ sv/lrupr_front.sv @@
// ----------------------------------------------------------------------------
// lrupr_front
// takes page references and holds them in a short queue for the back end
// ----------------------------------------------------------------------------
module lrupr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lrupr_pkg::PAGE_IN_W-1:0]   req_page_number,
   output lrupr_pkg::fq_head_type            head,
   input  logic                              pop
);

   logic [lrupr_pkg::PAGE_BITS-1:0] q_ff [lrupr_pkg::QUEUE_DEPTH];
   logic [lrupr_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lrupr_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lrupr_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                            push;
   logic                            do_pop;

   assign busy   = (cnt_ff == lrupr_pkg::QCNT_W'(lrupr_pkg::QUEUE_DEPTH));
   assign push   = start && !busy;
   assign do_pop = pop && (cnt_ff != '0);

   assign head.vld  = (cnt_ff != '0);
   assign head.page = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lrupr_pkg::QPTR_W'(lrupr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + lrupr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == lrupr_pkg::QPTR_W'(lrupr_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + lrupr_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + lrupr_pkg::QCNT_W'(1);
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - lrupr_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= lrupr_pkg::page_in(req_page_number);
      end
   end

endmodule

@@ sv/lrupr_back.sv @@
// ----------------------------------------------------------------------------
// lrupr_back
// tag lookup, victim choice and recency update, taking a new reference only after the last one's update
// ----------------------------------------------------------------------------
module lrupr_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lrupr_pkg::CSR_W-1:0]         csr_wr_data,
   input  lrupr_pkg::fq_head_type              head,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [lrupr_pkg::FRAME_OUT_W-1:0]   rsp_frame_used,
   output logic                                rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_IN_W-1:0]     rsp_evicted_page,
   output logic [lrupr_pkg::TOTAL_W-1:0]       rsp_hit_total,
   output logic [lrupr_pkg::TOTAL_W-1:0]       rsp_fault_total
);

   localparam int NF = lrupr_pkg::MAX_FRAMES;

   lrupr_pkg::bk_state_type state_ff, state_in;
   logic                    look;
   logic                    upd;

   logic [lrupr_pkg::CSR_W-1:0]     csr_ff;
   logic [lrupr_pkg::PAGE_BITS-1:0] page_ff  [NF];
   logic [NF-1:0]                   valid_ff;
   logic [lrupr_pkg::RANK_W-1:0]    rank_ff  [NF];
   logic [lrupr_pkg::TOTAL_W-1:0]   hit_cnt_ff, fault_cnt_ff;

   // lookup results held for the update cycle
   logic                            lk_hit_ff;
   logic                            lk_evict_ff;
   logic                            lk_all_ff;
   logic [lrupr_pkg::IDX_W-1:0]     lk_idx_ff;
   logic [lrupr_pkg::RANK_W-1:0]    lk_limit_ff;
   logic [lrupr_pkg::PAGE_BITS-1:0] lk_page_ff;
   logic [lrupr_pkg::PAGE_BITS-1:0] lk_ev_page_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   logic [lrupr_pkg::FRAME_OUT_W-1:0] rsp_frame_ff;
   logic                            rsp_ev_valid_ff;
   logic [lrupr_pkg::PAGE_IN_W-1:0] rsp_ev_page_ff;
   logic [lrupr_pkg::TOTAL_W-1:0]   rsp_hit_total_ff, rsp_fault_total_ff;

   logic [lrupr_pkg::NCNT_W-1:0]    n_act;
   logic [NF-1:0]                   active;
   logic [NF-1:0]                   match;
   logic [NF-1:0]                   empty;
   logic [NF-1:0]                   win;
   logic                            any_hit, any_empty;
   logic [lrupr_pkg::IDX_W-1:0]     hidx, eidx, vidx;

   always_comb begin
      state_in = state_ff;
      look     = 1'b0;
      upd      = 1'b0;
      unique case (state_ff)
         lrupr_pkg::BK_LOOK: begin
            if (head.vld) begin
               look     = 1'b1;
               state_in = lrupr_pkg::BK_UPDATE;
            end
         end
         lrupr_pkg::BK_UPDATE: begin
            upd      = 1'b1;
            state_in = lrupr_pkg::BK_LOOK;
         end
         default: state_in = lrupr_pkg::BK_LOOK;
      endcase
   end

   assign pop = look;

   // parallel tag compare and candidate search
   always_comb begin
      n_act = lrupr_pkg::active_count(csr_ff);
      for (int i = 0; i < NF; i++) begin
         active[i] = (i < int'(n_act));
         match[i]  = active[i] && valid_ff[i] && (page_ff[i] == head.page);
         empty[i]  = active[i] && !valid_ff[i];
      end
      any_hit   = |match;
      any_empty = |empty;
      hidx = '0;
      eidx = '0;
      for (int i = NF - 1; i >= 0; i--) begin
         if (match[i]) hidx = lrupr_pkg::IDX_W'(i);
         if (empty[i]) eidx = lrupr_pkg::IDX_W'(i);
      end
      // oldest frame wins, ties go to the lower frame
      for (int i = 0; i < NF; i++) begin
         win[i] = active[i];
         for (int j = 0; j < NF; j++) begin
            if (active[j] && (j < i) && !(rank_ff[i] > rank_ff[j])) win[i] = 1'b0;
            if (active[j] && (j > i) && (rank_ff[i] < rank_ff[j])) win[i] = 1'b0;
         end
      end
      vidx = '0;
      for (int i = NF - 1; i >= 0; i--) begin
         if (win[i]) vidx = lrupr_pkg::IDX_W'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrupr_pkg::BK_LOOK;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= lrupr_pkg::CSR_RESET;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (look) begin
         lk_hit_ff   <= any_hit;
         lk_evict_ff <= !any_hit && !any_empty;
         lk_all_ff   <= !any_hit;
         lk_idx_ff   <= any_hit ? hidx : (any_empty ? eidx : vidx);
         lk_limit_ff <= rank_ff[hidx];
         lk_page_ff  <= head.page;
         lk_ev_page_ff <= (!any_hit && !any_empty) ? page_ff[vidx] : '0;
      end
   end

   // aging, rank clear and valid bit write for the used frame
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NF; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (upd) begin
         for (int i = 0; i < NF; i++) begin
            if (active[i] && valid_ff[i] && (lrupr_pkg::IDX_W'(i) != lk_idx_ff) &&
                (lk_all_ff || (rank_ff[i] < lk_limit_ff)) &&
                (rank_ff[i] != lrupr_pkg::RANK_MAX)) begin
               rank_ff[i] <= rank_ff[i] + lrupr_pkg::RANK_W'(1);
            end
         end
         rank_ff[lk_idx_ff]  <= '0;
         valid_ff[lk_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (upd && !lk_hit_ff) begin
         page_ff[lk_idx_ff] <= lk_page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= upd;
         if (upd && lk_hit_ff) begin
            hit_cnt_ff <= lrupr_pkg::sat_inc(hit_cnt_ff);
         end
         if (upd && !lk_hit_ff) begin
            fault_cnt_ff <= lrupr_pkg::sat_inc(fault_cnt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         rsp_hit_ff         <= lk_hit_ff;
         rsp_frame_ff       <= lrupr_pkg::frame_out(lk_idx_ff);
         rsp_ev_valid_ff    <= lk_evict_ff;
         rsp_ev_page_ff     <= lrupr_pkg::page_out(lk_ev_page_ff);
         rsp_hit_total_ff   <= lk_hit_ff ? lrupr_pkg::sat_inc(hit_cnt_ff) : hit_cnt_ff;
         rsp_fault_total_ff <= lk_hit_ff ? fault_cnt_ff : lrupr_pkg::sat_inc(fault_cnt_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_used    = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_hit_total     = rsp_hit_total_ff;
   assign rsp_fault_total   = rsp_fault_total_ff;

endmodule
